>>> sv/bums_pkg.sv
// shared types and constants of the bottom-up merge sorter
// no dependencies; imported by the controller, the datapath and the top level
package bums_pkg;

   localparam int DEFAULT_DEPTH       = 64;
   localparam int DEFAULT_VALUE_WIDTH = 16;

   // comparison and move totals
   localparam int                    COUNT_WIDTH = 10;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;

   // controller to datapath commands
   typedef struct packed {
      logic data_wr_en;    // write data store
      logic data_from_req; // data store write takes the loaded value, else copy-back
      logic data_rd_en;    // read data store at both read addresses
      logic merge_wr_en;   // write merge store
      logic take_a;        // merge store write takes the left run head
      logic merge_rd_en;   // read merge store
      logic cmp_inc;       // one comparison made
      logic move_inc;      // one element moved
      logic cnt_clear;     // new sort, clear both totals
   } bums_cmd_type;

endpackage

>>> sv/bums_ifs.sv
// valid/ready channel interfaces of the bottom-up merge sorter
// standalone, no package needed
interface bums_req_if #(
   parameter int VALUE_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;
   logic                   is_last;

   modport source (output valid, value, is_last, input ready);
   modport sink   (input valid, value, is_last, output ready);
endinterface

interface bums_rsp_if #(
   parameter int VALUE_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] sorted_value;
   logic                   is_final;
   logic [9:0]             comparison_total;
   logic [9:0]             move_total;
   logic                   overflowed;

   modport source (output valid, sorted_value, is_final, comparison_total, move_total,
                   overflowed, input ready);
   modport sink   (input valid, sorted_value, is_final, comparison_total, move_total,
                   overflowed, output ready);
endinterface

>>> sv/bums_datapath.sv
// data store, merge store, head compare and the two saturating totals
// depends on bums_pkg
module bums_datapath #(
   parameter int DEPTH       = bums_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = bums_pkg::DEFAULT_VALUE_WIDTH,
   parameter int AW          = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  bums_pkg::bums_cmd_type           cmd,
   input  logic [AW-1:0]                    data_wr_addr,
   input  logic [AW-1:0]                    data_rd_a_addr,
   input  logic [AW-1:0]                    data_rd_b_addr,
   input  logic [AW-1:0]                    merge_wr_addr,
   input  logic [AW-1:0]                    merge_rd_addr,
   input  logic [VALUE_WIDTH-1:0]           load_value,
   output logic                             a_le_b,
   output logic [VALUE_WIDTH-1:0]           head_value,
   output logic [bums_pkg::COUNT_WIDTH-1:0] comparison_total,
   output logic [bums_pkg::COUNT_WIDTH-1:0] move_total
);
   import bums_pkg::*;

   logic [VALUE_WIDTH-1:0] data_store  [DEPTH];
   logic [VALUE_WIDTH-1:0] merge_store [DEPTH];

   logic [VALUE_WIDTH-1:0] rd_a_ff;
   logic [VALUE_WIDTH-1:0] rd_b_ff;
   logic [VALUE_WIDTH-1:0] rd_m_ff;
   logic [VALUE_WIDTH-1:0] data_wr_value;
   logic [VALUE_WIDTH-1:0] merge_wr_value;

   logic [COUNT_WIDTH-1:0] cmp_ff, cmp_in;
   logic [COUNT_WIDTH-1:0] move_ff, move_in;

   assign data_wr_value  = cmd.data_from_req ? load_value : rd_m_ff;
   assign merge_wr_value = cmd.take_a ? rd_a_ff : rd_b_ff;

   always_ff @(posedge clock) begin
      if (cmd.data_wr_en) begin
         data_store[data_wr_addr] <= data_wr_value;
      end
      if (cmd.data_rd_en) begin
         rd_a_ff <= data_store[data_rd_a_addr];
         rd_b_ff <= data_store[data_rd_b_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.merge_wr_en) begin
         merge_store[merge_wr_addr] <= merge_wr_value;
      end
      if (cmd.merge_rd_en) begin
         rd_m_ff <= merge_store[merge_rd_addr];
      end
   end

   // ties go left, keeps the sort stable
   assign a_le_b     = (rd_a_ff <= rd_b_ff);
   assign head_value = rd_a_ff;

   always_comb begin
      cmp_in  = cmp_ff;
      move_in = move_ff;
      if (cmd.cnt_clear) begin
         cmp_in  = '0;
         move_in = '0;
      end else begin
         if (cmd.cmp_inc && (cmp_ff != COUNT_MAX)) begin
            cmp_in = cmp_ff + COUNT_WIDTH'(1);
         end
         if (cmd.move_inc && (move_ff != COUNT_MAX)) begin
            move_in = move_ff + COUNT_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_ff  <= '0;
         move_ff <= '0;
      end else begin
         cmp_ff  <= cmp_in;
         move_ff <= move_in;
      end
   end

   assign comparison_total = cmp_ff;
   assign move_total       = move_ff;

endmodule

>>> sv/bums_controller.sv
// sequencer: load, run-width levels, pair merge, copy-back and result emission
// depends on bums_pkg
module bums_controller #(
   parameter int DEPTH = bums_pkg::DEFAULT_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_is_last,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_final,
   output logic                   rsp_overflowed,
   input  logic                   a_le_b,
   output bums_pkg::bums_cmd_type cmd,
   output logic [AW-1:0]          data_wr_addr,
   output logic [AW-1:0]          data_rd_a_addr,
   output logic [AW-1:0]          data_rd_b_addr,
   output logic [AW-1:0]          merge_wr_addr,
   output logic [AW-1:0]          merge_rd_addr
);
   import bums_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   // wide enough for run bounds before clipping (below three times the depth)
   localparam int PW = CW + 2;

   typedef enum logic [6:0] {
      S_LOAD    = 7'b0000001,
      S_LEVEL   = 7'b0000010,
      S_PAIR    = 7'b0000100,
      S_MERGE   = 7'b0001000,
      S_CPREP   = 7'b0010000,
      S_COPY    = 7'b0100000,
      S_EMIT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          overflow_ff, overflow_in;
   logic          emit_rd_ff, emit_rd_in;
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW-1:0] mid_ff, mid_in;
   logic [PW-1:0] hi_ff, hi_in;
   logic [PW-1:0] a_ff, a_in;
   logic [PW-1:0] b_ff, b_in;
   logic [PW-1:0] k_ff, k_in;

   logic [PW-1:0] n_ext;
   logic [PW-1:0] k_next;
   logic [PW-1:0] mid_sum;
   logic [PW-1:0] hi_sum;
   logic [PW-1:0] mid_clip;
   logic [PW-1:0] hi_clip;
   logic          a_ok;
   logic          b_ok;
   logic          take_a;

   assign n_ext    = PW'(count_ff);
   assign k_next   = k_ff + PW'(1);
   assign mid_sum  = lo_ff + width_ff;
   assign hi_sum   = lo_ff + (width_ff << 1);
   assign mid_clip = (mid_sum < n_ext) ? mid_sum : n_ext;
   assign hi_clip  = (hi_sum < n_ext) ? hi_sum : n_ext;
   assign a_ok     = (a_ff < mid_ff);
   assign b_ok     = (b_ff < hi_ff);
   assign take_a   = (a_ok && b_ok) ? a_le_b : a_ok;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      emit_rd_in  = emit_rd_ff;
      width_in    = width_ff;
      lo_in       = lo_ff;
      mid_in      = mid_ff;
      hi_in       = hi_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;

      cmd            = '0;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      data_wr_addr   = k_ff[AW-1:0];
      data_rd_a_addr = a_ff[AW-1:0];
      data_rd_b_addr = b_ff[AW-1:0];
      merge_wr_addr  = k_ff[AW-1:0];
      merge_rd_addr  = k_ff[AW-1:0];

      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CW'(DEPTH)) begin
                  cmd.data_wr_en    = 1'b1;
                  cmd.data_from_req = 1'b1;
                  data_wr_addr      = count_ff[AW-1:0];
                  count_in          = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_is_last) begin
                  cmd.cnt_clear = 1'b1;
                  width_in      = PW'(1);
                  state_in      = S_LEVEL;
               end
            end
         end

         S_LEVEL: begin
            if (width_ff >= n_ext) begin
               k_in       = '0;
               emit_rd_in = 1'b1;
               state_in   = S_EMIT;
            end else begin
               lo_in    = '0;
               state_in = S_PAIR;
            end
         end

         S_PAIR: begin
            if (lo_ff >= n_ext) begin
               width_in = width_ff << 1;
               state_in = S_LEVEL;
            end else begin
               mid_in         = mid_clip;
               hi_in          = hi_clip;
               a_in           = lo_ff;
               b_in           = mid_clip;
               k_in           = lo_ff;
               cmd.data_rd_en = 1'b1;
               data_rd_a_addr = lo_ff[AW-1:0];
               data_rd_b_addr = mid_clip[AW-1:0];
               state_in       = S_MERGE;
            end
         end

         S_MERGE: begin
            cmd.cmp_inc     = a_ok && b_ok;
            cmd.take_a      = take_a;
            cmd.merge_wr_en = 1'b1;
            cmd.move_inc    = 1'b1;
            a_in            = a_ff + PW'(take_a);
            b_in            = b_ff + PW'(!take_a);
            k_in            = k_next;
            // fetch the new run heads while the current ones are used
            cmd.data_rd_en  = 1'b1;
            data_rd_a_addr  = a_in[AW-1:0];
            data_rd_b_addr  = b_in[AW-1:0];
            if (k_next == hi_ff) begin
               state_in = S_CPREP;
            end
         end

         S_CPREP: begin
            cmd.merge_rd_en = 1'b1;
            merge_rd_addr   = lo_ff[AW-1:0];
            k_in            = lo_ff;
            state_in        = S_COPY;
         end

         S_COPY: begin
            cmd.data_wr_en  = 1'b1;
            cmd.move_inc    = 1'b1;
            cmd.merge_rd_en = 1'b1;
            merge_rd_addr   = k_next[AW-1:0];
            k_in            = k_next;
            if (k_next == hi_ff) begin
               lo_in    = hi_sum;
               state_in = S_PAIR;
            end
         end

         S_EMIT: begin
            // the head is fetched first, then one result per cycle while rsp_ready is high
            if (emit_rd_ff) begin
               cmd.data_rd_en = 1'b1;
               data_rd_a_addr = k_ff[AW-1:0];
               emit_rd_in     = 1'b0;
            end else begin
               rsp_valid = 1'b1;
               if (rsp_ready) begin
                  if (k_next == n_ext) begin
                     count_in    = '0;
                     overflow_in = 1'b0;
                     state_in    = S_LOAD;
                  end else begin
                     k_in           = k_next;
                     cmd.data_rd_en = 1'b1;
                     data_rd_a_addr = k_next[AW-1:0];
                  end
               end
            end
         end

         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_is_final   = (k_next == n_ext);
   assign rsp_overflowed = overflow_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         emit_rd_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         emit_rd_ff  <= emit_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff <= width_in;
      lo_ff    <= lo_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      k_ff     <= k_in;
   end

endmodule

>>> sv/bottom_up_merge_sorter.sv
// bottom-up merge sorter top level: controller and datapath joined by commands
// depends on bums_pkg, bums_ifs, bums_controller, bums_datapath
//
//   channel  direction  carries                                        accepted when
//   req_if   in         value, is_last                                 valid && ready
//   rsp_if   out        sorted_value, is_final, comparison_total,      valid && ready
//                       move_total, overflowed
//
// loading takes every valid transaction; the transaction marked is_last starts the sort
// sort of n elements: each level makes a single merge pass and a single copy-back pass
//   through the two stores
// emission: the first result is fetched, then one result per cycle while rsp_if.ready is high
// no input is taken from the sort start until the final result transaction
// reset is synchronous, stores are not cleared; unwritten entries may be read but go unused
// a stalled result holds its payload, since the read register only moves on a handshake
module bottom_up_merge_sorter #(
   parameter int DEPTH       = bums_pkg::DEFAULT_DEPTH,
   parameter int VALUE_WIDTH = bums_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   bums_req_if.sink   req_if,
   bums_rsp_if.source rsp_if
);
   import bums_pkg::*;

   localparam int AW = $clog2(DEPTH);

   bums_cmd_type cmd;
   logic [AW-1:0] data_wr_addr;
   logic [AW-1:0] data_rd_a_addr;
   logic [AW-1:0] data_rd_b_addr;
   logic [AW-1:0] merge_wr_addr;
   logic [AW-1:0] merge_rd_addr;
   logic          a_le_b;

   // sequencer owns the list length, run bounds and all handshakes
   bums_controller #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_is_last    (req_if.is_last),
      .req_ready      (req_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .rsp_is_final   (rsp_if.is_final),
      .rsp_overflowed (rsp_if.overflowed),
      .a_le_b         (a_le_b),
      .cmd            (cmd),
      .data_wr_addr   (data_wr_addr),
      .data_rd_a_addr (data_rd_a_addr),
      .data_rd_b_addr (data_rd_b_addr),
      .merge_wr_addr  (merge_wr_addr),
      .merge_rd_addr  (merge_rd_addr)
   );

   // two stores, the compare of the run heads and the totals
   bums_datapath #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .data_wr_addr     (data_wr_addr),
      .data_rd_a_addr   (data_rd_a_addr),
      .data_rd_b_addr   (data_rd_b_addr),
      .merge_wr_addr    (merge_wr_addr),
      .merge_rd_addr    (merge_rd_addr),
      .load_value       (req_if.value),
      .a_le_b           (a_le_b),
      .head_value       (rsp_if.sorted_value),
      .comparison_total (rsp_if.comparison_total),
      .move_total       (rsp_if.move_total)
   );

   // loading and emission never overlap
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_if.ready && rsp_if.valid))
      else $error("input taken while results pending");

   // final result hands the block back to loading
   a_final_to_load: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && rsp_if.is_final |=> req_if.ready)
      else $error("not ready for a new list after final result");

   // every comparison comes with a move
   a_cmp_le_move: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.comparison_total <= rsp_if.move_total))
      else $error("comparison total above move total");

   // totals stay fixed across the results of one list
   a_totals_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ready && !rsp_if.is_final |=>
         rsp_if.valid && $stable(rsp_if.move_total) && $stable(rsp_if.comparison_total))
      else $error("totals changed within one list");

endmodule

>>> tb/sv/tb_bottom_up_merge_sorter.sv
// self-checking testbench for the bottom-up merge sorter: loads lists, predicts sorted output
// depends on bums_pkg, bums_ifs (bums_req_if, bums_rsp_if) and bottom_up_merge_sorter
module tb_bottom_up_merge_sorter;
   import bums_pkg::*;

   localparam int LIST_DEPTH   = 64;
   localparam int VAL_W        = 16;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;
   localparam int TAIL_CYCLES  = 20;

   // one predicted result transaction
   typedef struct packed {
      logic [VAL_W-1:0]       sorted_value;
      logic                   is_final;
      logic [COUNT_WIDTH-1:0] comparison_total;
      logic [COUNT_WIDTH-1:0] move_total;
      logic                   overflowed;
   } sorted_entry_type;

   logic clock = 1'b0;
   logic reset;

   bums_req_if #(.VALUE_WIDTH(VAL_W)) req_ch ();
   bums_rsp_if #(.VALUE_WIDTH(VAL_W)) rsp_ch ();

   bottom_up_merge_sorter #(
      .DEPTH       (LIST_DEPTH),
      .VALUE_WIDTH (VAL_W)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // shadow of the list being loaded, mirrors what the block holds
   logic [VAL_W-1:0] loaded_values [LIST_DEPTH];
   int               loaded_count;
   bit               loaded_overflow;

   // sorted results still owed by the block, oldest first
   sorted_entry_type sorted_queue [$];

   int fail_count;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;

   always #1 clock = ~clock;

   // absorb one accepted transaction; on the list end, sort and queue the output
   function automatic void load_and_sort(logic [VAL_W-1:0] value, logic last);
      logic [VAL_W-1:0] scratch [LIST_DEPTH];
      int               n, width, lo, mid, hi, a, b, k;
      int               cmp_total, mov_total;
      bit               take_left;
      sorted_entry_type entry;

      if (loaded_count < LIST_DEPTH) begin
         loaded_values[loaded_count] = value;
         loaded_count++;
      end else begin
         // store full: value dropped, flag raised
         loaded_overflow = 1'b1;
      end
      if (!last) return;

      n         = loaded_count;
      cmp_total = 0;
      mov_total = 0;
      // merge runs of width 1, 2, 4 ... clipped at the list length
      for (width = 1; width < n; width = width * 2) begin
         for (lo = 0; lo < n; lo = lo + 2 * width) begin
            mid = (lo + width < n) ? lo + width : n;
            hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
            a   = lo;
            b   = mid;
            k   = lo;
            while (a < mid || b < hi) begin
               if (a < mid && b < hi) begin
                  if (cmp_total < COUNT_MAX) cmp_total++;
                  // ties take the left run
                  take_left = (loaded_values[a] <= loaded_values[b]);
               end else begin
                  take_left = (a < mid);
               end
               if (take_left) begin
                  scratch[k] = loaded_values[a];
                  a++;
               end else begin
                  scratch[k] = loaded_values[b];
                  b++;
               end
               k++;
               if (mov_total < COUNT_MAX) mov_total++;
            end
            // copy-back counts as moves too
            for (k = lo; k < hi; k++) begin
               loaded_values[k] = scratch[k];
               if (mov_total < COUNT_MAX) mov_total++;
            end
         end
      end

      for (k = 0; k < n; k++) begin
         entry.sorted_value     = loaded_values[k];
         entry.is_final         = (k == n - 1);
         entry.comparison_total = cmp_total[COUNT_WIDTH-1:0];
         entry.move_total       = mov_total[COUNT_WIDTH-1:0];
         entry.overflowed       = loaded_overflow;
         sorted_queue.push_back(entry);
      end
      loaded_count    = 0;
      loaded_overflow = 1'b0;
   endfunction

   // offer one value, idling at random first; valid stays high into the next call
   task automatic offer_value(input logic [VAL_W-1:0] value, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.value   = value;
      req_ch.is_last = last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      load_and_sort(value, last);
   endtask

   // drop valid once a test has nothing more to send
   task automatic stop_offering();
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_results_drained();
      while (sorted_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // receiver: random stalls, or a long hold-off when a test asks for one
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ch.ready = 1'b0;
         hold_cycles  = hold_cycles - 1;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // result checker: every result transaction against the oldest prediction
   always @(posedge clock) begin
      sorted_entry_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.sorted_value     = rsp_ch.sorted_value;
         got.is_final         = rsp_ch.is_final;
         got.comparison_total = rsp_ch.comparison_total;
         got.move_total       = rsp_ch.move_total;
         got.overflowed       = rsp_ch.overflowed;
         if (sorted_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected result: value %h final %b cmp %0d mov %0d ovf %b",
                        got.sorted_value, got.is_final, got.comparison_total,
                        got.move_total, got.overflowed);
         end else begin
            want = sorted_queue.pop_front();
            if (got.sorted_value !== want.sorted_value || got.is_final !== want.is_final ||
                got.comparison_total !== want.comparison_total ||
                got.move_total !== want.move_total || got.overflowed !== want.overflowed) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("mismatch: exp %h %b %0d %0d %b / got %h %b %0d %0d %b",
                           want.sorted_value, want.is_final, want.comparison_total,
                           want.move_total, want.overflowed, got.sorted_value, got.is_final,
                           got.comparison_total, got.move_total, got.overflowed);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // single-element lists of all ones and all zeros: no merge levels, both totals stay zero
   task automatic test_single_element();
      offer_value('1, 1'b1);
      offer_value('0, 1'b1);
      stop_offering();
      wait_results_drained();
   endtask

   // short list of field extremes with ties, in mixed order and of odd length
   task automatic test_extreme_values();
      logic [VAL_W-1:0] vals [11];
      int               i;
      vals = '{16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFE,
               16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};
      for (i = 0; i < 11; i++) offer_value(vals[i], i == 10);
      // two-element list in reverse order
      offer_value(16'h0002, 1'b0);
      offer_value(16'h0001, 1'b1);
      stop_offering();
      wait_results_drained();
   endtask

   // exactly DEPTH elements: fills the store with no overflow
   task automatic test_full_list();
      int i;
      for (i = 0; i < LIST_DEPTH; i++)
         offer_value(16'(LIST_DEPTH - i), i == LIST_DEPTH - 1);
      stop_offering();
      wait_results_drained();
   endtask

   // values beyond DEPTH are dropped; a dropped last value still starts the sort,
   // then the next list starts clean without the flag
   task automatic test_overflow();
      int i;
      for (i = 0; i < LIST_DEPTH + 3; i++)
         offer_value(16'($urandom_range(16'hFFFF)), i == LIST_DEPTH + 2);
      offer_value(16'h1234, 1'b0);
      offer_value(16'h1234, 1'b1);
      stop_offering();
      wait_results_drained();
   endtask

   // random lists, mostly short, some long, a few past DEPTH
   task automatic test_random_lists(input int target_items);
      int sent, len, pick, flavor, k;
      logic [VAL_W-1:0] v;
      sent = 0;
      while (sent < target_items) begin
         pick = $urandom_range(99);
         if (pick < 70)      len = $urandom_range(12, 1);
         else if (pick < 90) len = $urandom_range(40, 13);
         else if (pick < 97) len = $urandom_range(LIST_DEPTH, 41);
         else                len = $urandom_range(LIST_DEPTH + 8, LIST_DEPTH + 1);
         flavor = $urandom_range(3);
         for (k = 0; k < len; k++) begin
            case (flavor)
               0: v = 16'($urandom_range(7));                 // many ties
               1: v = $urandom_range(1) ? '1 : '0;            // extremes only
               default: v = 16'($urandom_range(16'hFFFF));
            endcase
            offer_value(v, k == len - 1);
         end
         sent = sent + len;
      end
      stop_offering();
      wait_results_drained();
   endtask

   // long receiver hold-off while lists keep coming: output stalls, input backs up
   task automatic test_output_hold_off();
      int l, k;
      hold_cycles = 400;
      for (l = 0; l < 3; l++)
         for (k = 0; k < 8; k++)
            offer_value(16'($urandom_range(16'hFFFF)), k == 7);
      stop_offering();
      wait_results_drained();
   endtask

   initial begin
      fail_count      = 0;
      cycle_count     = 0;
      hold_cycles     = 0;
      loaded_count    = 0;
      loaded_overflow = 1'b0;
      send_idle_pct   = 29;
      recv_idle_pct   = 66;
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.value    = '0;
      req_ch.is_last  = 1'b0;
      rsp_ch.ready    = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_single_element();
      test_extreme_values();
      test_full_list();
      test_overflow();

      // slow receiver
      test_random_lists(20);
      test_output_hold_off();
      // slow sender
      send_idle_pct = 66;
      recv_idle_pct = 29;
      test_random_lists(20);
      // full rate both ways
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lists(20);

      if (sorted_queue.size() != 0) fail_count++;
      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> bottom_up_merge_sorter.f
sv/bums_pkg.sv
sv/bums_ifs.sv
sv/bums_datapath.sv
sv/bums_controller.sv
sv/bottom_up_merge_sorter.sv
tb/sv/tb_bottom_up_merge_sorter.sv
